>>> rtl/core/rvc_pkg.sv
`timescale 1ns / 1ps
package rvc_pkg;

  localparam int IMEM_WORDS_DEF = 4096;
  localparam int DMEM_BYTES_DEF = 131072;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  localparam logic [6:0]  F7_ALT    = 7'h20;
  localparam logic [31:0] UIMM_MASK = 32'hFFFFF000;
  localparam logic [4:0]  SH_MASK   = 5'h1F;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_DRANGE  = 3'd3;
  localparam logic [2:0] ST_FRANGE  = 3'd4;
  localparam logic [2:0] ST_STOPPED = 3'd5;

  localparam logic [1:0] ACT_ILOAD = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_DREAD = 2'd2;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SLL, ALU_SRL, ALU_SRA
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

endpackage

>>> rtl/core/rvc_alu.sv
`timescale 1ns / 1ps
module rvc_alu
  import rvc_pkg::*;
(
  input  alu_req_t    req,
  output logic [31:0] y
);

  logic [4:0] sh;
  assign sh = req.b[4:0] & SH_MASK;

  always_comb begin
    unique case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_SUB: y = req.a - req.b;
      ALU_AND: y = req.a & req.b;
      ALU_OR:  y = req.a | req.b;
      ALU_XOR: y = req.a ^ req.b;
      ALU_SLL: y = req.a << sh;
      ALU_SRL: y = req.a >> sh;
      ALU_SRA: y = $unsigned($signed(req.a) >>> sh);
      default: y = '0;
    endcase
  end

endmodule

>>> rtl/core/rv32i_subset_core_step.sv
`timescale 1ns / 1ps
// Channel  | ports                                              | handshake
// ---------+----------------------------------------------------+--------------------------
// input    | in_action, in_index, in_word                       | start & !busy
// result   | out_pc, out_insn, out_status, out_unaligned,       | out_valid, one cycle,
//          | out_reg_*, out_mem_write, out_mem_addr, out_mem_data| no back-pressure
// config   | psel, penable, pwrite, paddr, pwdata, prdata       | APB, pready tied high
//
// Execute steps: fetch, decode, shared ALU, then writeback or branch target on the same ALU;
// lw adds a data read step, illegal or halt end in the ALU step, and a stopped core or an
// out-of-range fetch answers from idle, as do instruction load and unused actions; a data
// read adds a read step. The result word appears in the cycle after the last step, with
// busy low. The receiver cannot stall. After reset a clearing pass zeroes both memories;
// busy stays high, config writes are still taken.
module rv32i_subset_core_step
  import rvc_pkg::*;
#(
  parameter int IMEM_WORDS = IMEM_WORDS_DEF,
  parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [16:0] in_index,
  input  logic [31:0] in_word,
  output logic        out_valid,
  output logic [31:0] out_pc,
  output logic [31:0] out_insn,
  output logic [2:0]  out_status,
  output logic        out_unaligned,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_mem_write,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_mem_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DROWS   = DMEM_BYTES / 4;
  localparam int CLR_LEN = (IMEM_WORDS > DROWS) ? IMEM_WORDS : DROWS;
  localparam int IA_W    = $clog2(IMEM_WORDS);
  localparam int DR_W    = $clog2(DROWS);
  localparam int CL_W    = $clog2(CLR_LEN);
  localparam logic [32:0] IMEM_LIM = 33'(IMEM_WORDS);
  localparam logic [32:0] DMEM_LIM = 33'(DMEM_BYTES);
  localparam logic [32:0] DROW_LIM = 33'(DROWS);
  localparam logic [CL_W-1:0] CLR_LAST = CL_W'(CLR_LEN - 1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_DEC, S_EX1, S_EX2, S_LD, S_RD} state_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] insn;
    logic [2:0]  status;
    logic        unaligned;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
  } rsp_t;

  state_t          state_r, state_nxt;
  logic [31:0]     pc_r, pc_nxt;
  logic            stopped_r, stopped_nxt;
  logic            flag_r;
  logic [CL_W-1:0] clr_cnt_r;
  logic [31:0]     insn_r, alu_r;
  logic [1:0]      alo_r;
  logic            out_valid_r;
  rsp_t            rsp_r, rsp;
  logic            fire;
  // hold the data read address for the response of a data read
  logic [16:0]     in_index_q;

  // memories and read data
  logic [31:0] imem [IMEM_WORDS];
  logic [31:0] imem_q;
  logic [31:0] rf [32];
  logic [31:0] rf_v;
  logic [31:0] rf_q1, rf_q2;
  logic        rf_v1, rf_v2;
  logic [3:0][7:0] dq;

  // memory controls
  logic              imem_we;
  logic [IA_W-1:0]   imem_wa;
  logic [31:0]       imem_wd;
  logic              rf_re, rf_we;
  logic [4:0]        rf_wa;
  logic [31:0]       rf_wd;
  logic              d_re, d_we, d_clr;
  logic [31:0]       daddr;

  logic        accept;
  logic [31:0] idx32, pc4;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] immi, imms, offb, offj, immu;
  logic [31:0] a_op, b_op;
  logic [3:0][7:0] sw_b;
  logic [31:0] ld_word;
  logic        illegal, halt, d_ok, unal, taken;
  alu_req_t    areq;
  logic [31:0] alu_y;

  rvc_alu u_alu (.req(areq), .y(alu_y));

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign idx32  = {15'b0, in_index};
  assign pc4    = pc_r + 32'd4;

  assign opc  = insn_r[6:0];
  assign f3   = insn_r[14:12];
  assign f7   = insn_r[31:25];
  assign rd   = insn_r[11:7];
  assign rs1  = imem_q[19:15];
  assign rs2  = imem_q[24:20];
  assign immi = {{20{insn_r[31]}}, insn_r[31:20]};
  assign imms = {{20{insn_r[31]}}, insn_r[31:25], insn_r[11:7]};
  assign offb = {{19{insn_r[31]}}, insn_r[31], insn_r[7], insn_r[30:25], insn_r[11:8], 1'b0};
  assign offj = {{11{insn_r[31]}}, insn_r[31], insn_r[19:12], insn_r[20],
                 insn_r[30:21], 1'b0};
  assign immu = insn_r & UIMM_MASK;
  assign a_op = rf_v1 ? rf_q1 : 32'd0;
  assign b_op = rf_v2 ? rf_q2 : 32'd0;
  assign sw_b = b_op;
  assign halt = (opc == OPC_JAL) && (rd == 5'd0) && (offj == 32'd0);
  assign d_ok = ({1'b0, daddr} + 33'd4) <= DMEM_LIM;
  assign unal = flag_r && (alu_r[1:0] != 2'd0);
  assign taken = f3[0] ? (alu_r != 32'd0) : (alu_r == 32'd0);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_word[8*k +: 8] = dq[2'(alo_r + 2'(k))];
    end
  end

  always_comb begin
    unique case (opc)
      OPC_OP: illegal = !(((f7 == 7'd0) && (f3 != 3'd2) && (f3 != 3'd3)) ||
                          ((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5))));
      OPC_OPIMM:  illegal = (f3 != 3'd0);
      OPC_LOAD, OPC_STORE: illegal = (f3 != 3'd2);
      OPC_BRANCH: illegal = (f3[2:1] != 2'd0);
      OPC_JAL, OPC_JALR, OPC_LUI, OPC_AUIPC: illegal = 1'b0;
      default:    illegal = 1'b1;
    endcase
  end

  // shared ALU: main operation in EX1, branch target in EX2
  always_comb begin
    areq = '{op: ALU_ADD, a: 32'd0, b: 32'd0};
    if (state_r == S_EX1) begin
      unique case (opc)
        OPC_OP: begin
          areq.a = a_op;
          areq.b = b_op;
          unique case (f3)
            3'd0:    areq.op = f7[5] ? ALU_SUB : ALU_ADD;
            3'd1:    areq.op = ALU_SLL;
            3'd4:    areq.op = ALU_XOR;
            3'd5:    areq.op = f7[5] ? ALU_SRA : ALU_SRL;
            3'd6:    areq.op = ALU_OR;
            3'd7:    areq.op = ALU_AND;
            default: areq.op = ALU_ADD;
          endcase
        end
        OPC_OPIMM, OPC_LOAD, OPC_JALR: begin
          areq.a = a_op;
          areq.b = immi;
        end
        OPC_STORE: begin
          areq.a = a_op;
          areq.b = imms;
        end
        OPC_BRANCH: begin
          areq.op = ALU_SUB;
          areq.a  = a_op;
          areq.b  = b_op;
        end
        OPC_JAL: begin
          areq.a = pc_r;
          areq.b = offj;
        end
        OPC_LUI:   areq.b = immu;
        OPC_AUIPC: begin
          areq.a = pc_r;
          areq.b = immu;
        end
        default: areq.b = 32'd0;
      endcase
    end else if (state_r == S_EX2) begin
      areq.a = pc_r;
      areq.b = offb;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    stopped_nxt = stopped_r;
    fire        = 1'b0;
    rsp         = '0;
    rsp.pc      = pc_r;
    imem_we     = 1'b0;
    imem_wa     = idx32[IA_W-1:0];
    imem_wd     = in_word;
    rf_re       = 1'b0;
    rf_we       = 1'b0;
    rf_wa       = rd;
    rf_wd       = alu_r;
    d_re        = 1'b0;
    d_we        = 1'b0;
    d_clr       = 1'b0;
    daddr       = alu_r;
    unique case (state_r)
      S_CLR: begin
        imem_we = ({1'b0, 32'(clr_cnt_r)} < IMEM_LIM);
        imem_wa = clr_cnt_r[IA_W-1:0];
        imem_wd = 32'd0;
        d_clr   = ({1'b0, 32'(clr_cnt_r)} < DROW_LIM);
        if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        daddr = idx32;
        if (accept) begin
          priority case (in_action)
            ACT_ILOAD: begin
              fire     = 1'b1;
              rsp.insn = in_word;
              if ({1'b0, idx32} < IMEM_LIM) imem_we = 1'b1;
              else rsp.status = ST_FRANGE;
            end
            ACT_DREAD: begin
              if (d_ok) begin
                d_re      = 1'b1;
                state_nxt = S_RD;
              end else begin
                fire         = 1'b1;
                rsp.mem_addr = idx32;
                rsp.status   = ST_DRANGE;
              end
            end
            ACT_EXEC: begin
              if (stopped_r) begin
                fire       = 1'b1;
                rsp.status = ST_STOPPED;
              end else if ((pc_r[1:0] != 2'd0) || ({3'b0, pc_r[31:2]} >= IMEM_LIM)) begin
                fire        = 1'b1;
                rsp.status  = ST_FRANGE;
                stopped_nxt = 1'b1;
              end else begin
                state_nxt = S_DEC;
              end
            end
            default: fire = 1'b1;
          endcase
        end
      end
      S_RD: begin
        fire         = 1'b1;
        rsp.mem_addr = {15'b0, in_index_q};
        rsp.mem_data = ld_word;
        state_nxt    = S_IDLE;
      end
      S_DEC: begin
        rf_re     = 1'b1;
        state_nxt = S_EX1;
      end
      S_EX1: begin
        rsp.insn = insn_r;
        if (illegal) begin
          fire        = 1'b1;
          rsp.status  = ST_ILLEGAL;
          stopped_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end else if (halt) begin
          fire        = 1'b1;
          rsp.status  = ST_HALT;
          stopped_nxt = 1'b1;
          pc_nxt      = pc4;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_EX2;
        end
      end
      S_EX2: begin
        rsp.insn = insn_r;
        if ((opc == OPC_LOAD) || (opc == OPC_STORE)) begin
          rsp.mem_addr  = alu_r;
          rsp.unaligned = unal;
          if (!d_ok) begin
            fire        = 1'b1;
            rsp.status  = ST_DRANGE;
            stopped_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else if (opc == OPC_STORE) begin
            fire          = 1'b1;
            d_we          = 1'b1;
            rsp.mem_write = 1'b1;
            rsp.mem_data  = b_op;
            pc_nxt        = pc4;
            state_nxt     = S_IDLE;
          end else begin
            d_re      = 1'b1;
            state_nxt = S_LD;
          end
        end else begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
          rf_we     = (opc != OPC_BRANCH) && (rd != 5'd0);
          if ((opc == OPC_JAL) || (opc == OPC_JALR)) rf_wd = pc4;
          priority case (opc)
            OPC_BRANCH: pc_nxt = taken ? alu_y : pc4;
            OPC_JAL:    pc_nxt = alu_r;
            OPC_JALR:   pc_nxt = {alu_r[31:1], 1'b0};
            default:    pc_nxt = pc4;
          endcase
          rsp.reg_write = rf_we;
          rsp.reg_index = rf_we ? rd : 5'd0;
          rsp.reg_value = rf_we ? rf_wd : 32'd0;
        end
      end
      S_LD: begin
        fire          = 1'b1;
        rsp.insn      = insn_r;
        rsp.mem_addr  = alu_r;
        rsp.unaligned = unal;
        rsp.mem_data  = ld_word;
        rf_wd         = ld_word;
        rf_we         = (rd != 5'd0);
        rsp.reg_write = rf_we;
        rsp.reg_index = rf_we ? rd : 5'd0;
        rsp.reg_value = rf_we ? ld_word : 32'd0;
        pc_nxt        = pc4;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pc_r        <= 32'd0;
      stopped_r   <= 1'b0;
      flag_r      <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rf_v        <= '0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= fire;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (psel && penable && pwrite && !paddr[2]) flag_r <= pwdata[0];
      if (rf_we) rf_v[rf_wa] <= 1'b1;
    end
    if (fire) rsp_r <= rsp;
    if (state_r == S_DEC) insn_r <= imem_q;
    if (state_r == S_EX1) alu_r <= alu_y;
    if (d_re) alo_r <= daddr[1:0];
    if (accept) in_index_q <= in_index;
  end

  // instruction store: one write, one registered read at the pc
  always_ff @(posedge clk) begin
    if (imem_we) imem[imem_wa] <= imem_wd;
    imem_q <= imem[pc_r[IA_W+1:2]];
  end

  // register file: two registered reads, one write
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rf_re) begin
      rf_q1 <= rf[rs1];
      rf_q2 <= rf[rs2];
      rf_v1 <= rf_v[rs1];
      rf_v2 <= rf_v[rs2];
    end
  end

  // data store: four byte banks, a word at any byte address touches each bank once
  for (genvar j = 0; j < 4; j++) begin : g_bank
    localparam logic [1:0] J = 2'(j);
    logic [7:0]      bank [DROWS];
    logic [DR_W-1:0] row;
    logic [1:0]      k;

    assign k   = J - daddr[1:0];
    assign row = d_clr ? clr_cnt_r[DR_W-1:0]
                       : daddr[DR_W+1:2] + DR_W'(J < daddr[1:0]);

    always_ff @(posedge clk) begin
      if (d_clr || d_we) bank[row] <= d_clr ? 8'd0 : sw_b[k];
      if (d_re) dq[j] <= bank[row];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pc        = rsp_r.pc;
  assign out_insn      = rsp_r.insn;
  assign out_status    = rsp_r.status;
  assign out_unaligned = rsp_r.unaligned;
  assign out_reg_write = rsp_r.reg_write;
  assign out_reg_index = rsp_r.reg_index;
  assign out_reg_value = rsp_r.reg_value;
  assign out_mem_write = rsp_r.mem_write;
  assign out_mem_addr  = rsp_r.mem_addr;
  assign out_mem_data  = rsp_r.mem_data;
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? 32'd0 : {31'b0, flag_r};

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted word produced neither work nor a result");

  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped core resumed without reset");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_write) |-> (out_reg_index != 5'd0))
    else $error("write to x0 reported");

  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_HALT || out_status == ST_ILLEGAL)) |-> stopped_r)
    else $error("halt or illegal without stopping");

endmodule
